FILE: rtl/xsf_pkg.sv
// Shared types and constants for the XOR sprite framebuffer.
`default_nettype none
package xsf_pkg;

  localparam int SCREEN_COLS     = 64;
  localparam int SCREEN_LINES    = 32;
  localparam int MAX_SPRITE_ROWS = 16;

  localparam int COL_W   = $clog2(SCREEN_COLS);
  localparam int LINE_AW = $clog2(SCREEN_LINES);
  // wide enough for y_pos + row_index and for the moduli themselves
  localparam int VAL_W   = 9;
  localparam int PIX_W   = 64;
  localparam int EXT_W   = (SCREEN_COLS > PIX_W) ? SCREEN_COLS : PIX_W;

  typedef logic [SCREEN_COLS-1:0] line_t;
  typedef logic [LINE_AW-1:0]     line_addr_t;
  typedef logic [VAL_W-1:0]       val_t;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE,
    ST_COL,
    ST_MERGE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic       clr_all;
    line_addr_t addr;
    line_t      wdata;
  } mem_req_t;

endpackage
`default_nettype wire

FILE: rtl/xsf_mod_unit.sv
// Iterative modulo reduction: one compare-and-subtract per cycle.
`default_nettype none
module xsf_mod_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire xsf_pkg::val_t value,
  input  wire xsf_pkg::val_t modulus,
  output logic               done,
  output xsf_pkg::val_t      result
);
  import xsf_pkg::*;

  val_t acc_r;
  val_t mod_r;
  logic busy_r;
  logic ge;

  assign ge     = (acc_r >= mod_r);
  assign done   = busy_r && !ge;
  assign result = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && !ge) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= value;
      mod_r <= modulus;
    end else if (busy_r && ge) begin
      acc_r <= acc_r - mod_r;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/xsf_frame_mem.sv
// Frame line store with per-line valid bits; invalid lines read as zero.
`default_nettype none
module xsf_frame_mem (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire xsf_pkg::mem_req_t req,
  output xsf_pkg::line_t        rd_data
);
  import xsf_pkg::*;

  line_t                   mem [SCREEN_LINES];
  logic [SCREEN_LINES-1:0] valid_r;
  line_t                   rd_data_r;
  logic                    rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.clr_all) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule
`default_nettype wire

FILE: rtl/xor_sprite_framebuffer_unit.sv
// XOR sprite framebuffer: 1-bit frame, sprite row draw, clear and line read.
//
// Input channel (in_valid/in_ready) carries one request per transaction:
// clear, draw one 8-pixel sprite row, or read one display line. Every
// request yields exactly one result transaction on out_valid/out_ready.
// One request is in flight at a time; in_ready is high only when idle.
//
// Clear, unknown requests and draws with row_index out of range go straight
// to the result; a read first wraps read_line by SCREEN_LINES, and a draw
// wraps y_pos + row_index by SCREEN_LINES and then x_pos by SCREEN_COLS.
// The wrap of line and column goes through one shared subtract unit that
// removes one modulus per cycle; a draw then does a read-modify-write of
// the single addressed frame line through a one-port line memory.
// Next request is taken the cycle after the result is taken.
//
// Reset clears all line valid bits (frame reads as zero) and the collision
// accumulator. While out_ready is low, the result holds and nothing else
// is accepted.
`default_nettype none
module xor_sprite_framebuffer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_x_pos,
  input  wire logic [7:0]  in_y_pos,
  input  wire logic [3:0]  in_row_index,
  input  wire logic [7:0]  in_sprite_row,
  input  wire logic        in_last_row,
  input  wire logic [4:0]  in_read_line,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_collision,
  output logic             out_sprite_done,
  output logic [63:0]      out_line_pixels
);
  import xsf_pkg::*;

  state_t state_r, state_nxt;

  logic [1:0]  req_r;
  logic [7:0]  x_r;
  logic [7:0]  sprite_r;
  logic        last_r;
  line_addr_t  line_r, line_nxt;
  logic [COL_W-1:0] base_col_r, base_col_nxt;

  logic        coll_r, coll_nxt;
  logic        out_coll_r, out_coll_nxt;
  logic        out_done_r, out_done_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;

  logic        mod_start;
  val_t        mod_value;
  val_t        mod_modulus;
  logic        mod_done;
  val_t        mod_result;

  mem_req_t    mem_req;
  line_t       rd_data;

  line_t       draw_mask;
  logic        hit;
  logic [EXT_W-1:0] rd_ext;
  logic        accept;

  xsf_mod_unit u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .value   (mod_value),
    .modulus (mod_modulus),
    .done    (mod_done),
    .result  (mod_result)
  );

  xsf_frame_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign accept = in_valid && in_ready;

  // eight pixel mask, each column wrapped once (base < SCREEN_COLS)
  always_comb begin
    logic [COL_W:0] c;
    draw_mask = '0;
    for (int i = 0; i < 8; i++) begin
      c = {1'b0, base_col_r} + (COL_W+1)'(i);
      if (c >= (COL_W+1)'(SCREEN_COLS)) begin
        c = c - (COL_W+1)'(SCREEN_COLS);
      end
      if (sprite_r[7-i]) begin
        draw_mask[c[COL_W-1:0]] = 1'b1;
      end
    end
  end

  assign hit    = |(rd_data & draw_mask);
  assign rd_ext = EXT_W'(rd_data);

  always_comb begin
    state_nxt    = state_r;
    line_nxt     = line_r;
    base_col_nxt = base_col_r;
    coll_nxt     = coll_r;
    out_coll_nxt = out_coll_r;
    out_done_nxt = out_done_r;
    out_pix_nxt  = out_pix_r;
    mod_start    = 1'b0;
    mod_value    = '0;
    mod_modulus  = VAL_W'(SCREEN_LINES);
    mem_req      = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          out_coll_nxt = coll_r;
          out_done_nxt = 1'b0;
          out_pix_nxt  = '0;
          case (in_req_type)
            REQ_CLEAR: begin
              mem_req.clr_all = 1'b1;
              state_nxt       = ST_RESP;
            end
            REQ_DRAW: begin
              if (32'(in_row_index) < MAX_SPRITE_ROWS) begin
                mod_start = 1'b1;
                mod_value = VAL_W'(in_y_pos) + VAL_W'(in_row_index);
                state_nxt = ST_LINE;
              end else begin
                out_done_nxt = in_last_row;
                if (in_last_row) begin
                  coll_nxt = 1'b0;
                end
                state_nxt = ST_RESP;
              end
            end
            REQ_READ: begin
              mod_start = 1'b1;
              mod_value = VAL_W'(in_read_line);
              state_nxt = ST_LINE;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_LINE: begin
        if (mod_done) begin
          line_nxt = line_addr_t'(mod_result);
          if (req_r == REQ_DRAW) begin
            mod_start   = 1'b1;
            mod_value   = VAL_W'(x_r);
            mod_modulus = VAL_W'(SCREEN_COLS);
            state_nxt   = ST_COL;
          end else begin
            mem_req.rd_en = 1'b1;
            mem_req.addr  = line_addr_t'(mod_result);
            state_nxt     = ST_MERGE;
          end
        end
      end
      ST_COL: begin
        mod_modulus = VAL_W'(SCREEN_COLS);
        if (mod_done) begin
          base_col_nxt  = mod_result[COL_W-1:0];
          mem_req.rd_en = 1'b1;
          mem_req.addr  = line_r;
          state_nxt     = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (req_r == REQ_DRAW) begin
          mem_req.wr_en = 1'b1;
          mem_req.addr  = line_r;
          mem_req.wdata = rd_data ^ draw_mask;
          out_coll_nxt  = coll_r | hit;
          out_done_nxt  = last_r;
          coll_nxt      = last_r ? 1'b0 : (coll_r | hit);
        end else begin
          out_pix_nxt = rd_ext[PIX_W-1:0];
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      coll_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      coll_r  <= coll_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_req_type;
      x_r      <= in_x_pos;
      sprite_r <= in_sprite_row;
      last_r   <= in_last_row;
    end
    line_r     <= line_nxt;
    base_col_r <= base_col_nxt;
    out_coll_r <= out_coll_nxt;
    out_done_r <= out_done_nxt;
    out_pix_r  <= out_pix_nxt;
  end

  assign out_collision   = out_coll_r;
  assign out_sprite_done = out_done_r;
  assign out_line_pixels = out_pix_r;

endmodule
`default_nettype wire

FILE: rtl/xsf_checker.sv
// Port-level checks for the XOR sprite framebuffer, bound to the top level.
`default_nettype none
module xsf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_collision,
  input wire logic        out_sprite_done,
  input wire logic [63:0] out_line_pixels
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_collision)
      && $stable(out_sprite_done) && $stable(out_line_pixels))
    else $error("result changed while stalled");

  // one transaction in flight: no accept while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // every accept drops ready in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // a sprite-ending result never carries line data
  a_done_no_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sprite_done |-> out_line_pixels == 64'd0)
    else $error("line data on draw result");

endmodule

bind xor_sprite_framebuffer_unit xsf_checker u_xsf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_collision   (out_collision),
  .out_sprite_done (out_sprite_done),
  .out_line_pixels (out_line_pixels)
);
`default_nettype wire
